FILE: src/rgb2hsv_pkg.sv
// Shared types and register map of the RGB to HSV and negative pixel converter.
package rgb2hsv_pkg;

	// Which component holds the maximum; ties go to red, then green.
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} hue_sector_t;

	// Word index of the swap configuration register on the APB port.
	localparam logic REG_SWAP_RED_BLUE = 1'b0;

	// Reset value of the red/blue swap control.
	localparam logic SWAP_RESET = 1'b1;

endpackage

FILE: src/rgb_to_hsv_negative_top.sv
// Pipelined pixel converter giving the negative and the HSV triple of each RGB pixel.
//
// The block takes one pixel per clock on the slave stream while the master side does
// not stall and gives one result per pixel on the master stream, in order. NSTG, the
// width of each quotient, is the larger of COMPONENT_BITS and the hue quotient width
// (11 by default). The rate of one pixel per cycle is set by the divider pipeline,
// which settles one quotient bit of saturation and of hue in each stage. A stall
// on the master side holds every stage at once. Register 0 (swap_red_blue, reset 1)
// swaps the first and third input components so that BGR input is read as RGB.
module rgb_to_hsv_negative_top
	import rgb2hsv_pkg::*;
#(
	parameter int COMPONENT_BITS    = 8,
	parameter int HUE_FRACTION_BITS = 4,
	localparam int CB    = COMPONENT_BITS,
	localparam int HUE_W = $clog2(360 << HUE_FRACTION_BITS),
	localparam int IN_W  = ((3 * CB + 7) / 8) * 8,
	localparam int OUT_W = ((5 * CB + HUE_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             s_tvalid,
	output logic             s_tready,
	// first_component, green_component, third_component
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// neg_red, neg_green, neg_blue, value_level, saturation_level, hue_angle
	output logic [OUT_W-1:0] m_tdata
);

	localparam int HS    = 1 << HUE_FRACTION_BITS;
	localparam int QH    = $clog2(120 * HS + 1);
	localparam int NSTG  = (QH > CB) ? QH : CB;
	localparam int DIV_W = CB + NSTG;

	localparam logic [CB-1:0]    FULL      = {CB{1'b1}};
	localparam logic [DIV_W-1:0] HUE_SPAN  = DIV_W'(60 * HS);
	localparam logic [HUE_W:0]   HUE_TURN  = (HUE_W + 1)'(360 * HS);
	localparam logic [HUE_W:0]   OFS_RED   = (HUE_W + 1)'(300 * HS);
	localparam logic [HUE_W:0]   OFS_GREEN = (HUE_W + 1)'(60 * HS);
	localparam logic [HUE_W:0]   OFS_BLUE  = (HUE_W + 1)'(180 * HS);

	typedef struct packed {
		logic [CB-1:0] neg_red;
		logic [CB-1:0] neg_green;
		logic [CB-1:0] neg_blue;
		logic [CB-1:0] mx;
		logic [CB-1:0] d;
		hue_sector_t   sec;
		logic          gray;
		logic          black;
	} pay_t;

	logic swap_q;
	logic cfg_wr;
	logic adv;

	// Stage 1: component order, maximum, minimum and sector.
	logic [CB-1:0] c0, cg, c2, r_c, b_c, mx_c, mn_c;
	hue_sector_t   sec_c;
	logic          v_s1;
	logic [CB-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	hue_sector_t   sec_s1;

	// Stage 2 and the divider stages share one chain of arrays; element 0 is stage 2.
	logic [CB-1:0]    d_c;
	logic [CB:0]      e_c;
	logic [2*CB-1:0]  satn_c;
	logic             v_sd   [0:NSTG];
	pay_t             pay_sd [0:NSTG];
	logic [DIV_W-1:0] srem_sd [0:NSTG];
	logic [DIV_W-1:0] hrem_sd [0:NSTG];
	logic [NSTG-1:0]  sq_sd  [0:NSTG];
	logic [NSTG-1:0]  hq_sd  [0:NSTG];
	logic [DIV_W-1:0] srem_nx [0:NSTG-1];
	logic [DIV_W-1:0] hrem_nx [0:NSTG-1];
	logic             sbit   [0:NSTG-1];
	logic             hbit   [0:NSTG-1];

	// Output stage.
	logic [HUE_W:0]   hsum_c, hwrap_c, hofs_c;
	logic             out_v_q;
	logic [CB-1:0]    nr_q, ng_q, nb_q, val_q, sat_q;
	logic [HUE_W-1:0] hue_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_SWAP_RED_BLUE) ? {31'b0, swap_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= SWAP_RESET;
		end else if (cfg_wr && (paddr[2] == REG_SWAP_RED_BLUE)) begin
			swap_q <= pwdata[0];
		end
	end

	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;

	always_comb begin
		c0   = s_tdata[CB-1:0];
		cg   = s_tdata[2*CB-1:CB];
		c2   = s_tdata[3*CB-1:2*CB];
		r_c  = swap_q ? c2 : c0;
		b_c  = swap_q ? c0 : c2;
		if ((r_c >= cg) && (r_c >= b_c)) begin
			sec_c = SEC_RED;
			mx_c  = r_c;
		end else if (cg >= b_c) begin
			sec_c = SEC_GREEN;
			mx_c  = cg;
		end else begin
			sec_c = SEC_BLUE;
			mx_c  = b_c;
		end
		mn_c = (r_c < cg) ? r_c : cg;
		if (b_c < mn_c) begin
			mn_c = b_c;
		end
	end

	always_comb begin
		d_c = mx_s1 - mn_s1;
		case (sec_s1)
			SEC_RED:   e_c = {1'b0, g_s1} + {1'b0, d_c} - {1'b0, b_s1};
			SEC_GREEN: e_c = {1'b0, b_s1} + {1'b0, d_c} - {1'b0, r_s1};
			SEC_BLUE:  e_c = {1'b0, r_s1} + {1'b0, d_c} - {1'b0, g_s1};
			default:   e_c = '0;
		endcase
		satn_c = (2 * CB)'(FULL) * (2 * CB)'(d_c);
	end

	// Each divider stage settles one quotient bit by a trial subtraction.
	always_comb begin
		for (int k = 0; k < NSTG; k++) begin
			logic [DIV_W-1:0] sdiv;
			logic [DIV_W-1:0] hdiv;
			sdiv = DIV_W'(pay_sd[k].mx) << (NSTG - 1 - k);
			hdiv = DIV_W'(pay_sd[k].d) << (NSTG - 1 - k);
			sbit[k]    = (srem_sd[k] >= sdiv);
			hbit[k]    = (hrem_sd[k] >= hdiv);
			srem_nx[k] = sbit[k] ? (srem_sd[k] - sdiv) : srem_sd[k];
			hrem_nx[k] = hbit[k] ? (hrem_sd[k] - hdiv) : hrem_sd[k];
		end
	end

	always_comb begin
		case (pay_sd[NSTG].sec)
			SEC_RED:   hofs_c = OFS_RED;
			SEC_GREEN: hofs_c = OFS_GREEN;
			SEC_BLUE:  hofs_c = OFS_BLUE;
			default:   hofs_c = '0;
		endcase
		hsum_c  = hofs_c + (HUE_W + 1)'(hq_sd[NSTG]);
		hwrap_c = (hsum_c >= HUE_TURN) ? (hsum_c - HUE_TURN) : hsum_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k <= NSTG; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= s_tvalid;
			v_sd[0] <= v_s1;
			for (int k = 0; k < NSTG; k++) begin
				v_sd[k+1] <= v_sd[k];
			end
			out_v_q <= v_sd[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1   <= r_c;
			g_s1   <= cg;
			b_s1   <= b_c;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sec_s1 <= sec_c;

			pay_sd[0].neg_red   <= ~r_s1;
			pay_sd[0].neg_green <= ~g_s1;
			pay_sd[0].neg_blue  <= ~b_s1;
			pay_sd[0].mx        <= mx_s1;
			pay_sd[0].d         <= d_c;
			pay_sd[0].sec       <= sec_s1;
			pay_sd[0].gray      <= (d_c == '0);
			pay_sd[0].black     <= (mx_s1 == '0);
			srem_sd[0]          <= DIV_W'(satn_c);
			hrem_sd[0]          <= HUE_SPAN * DIV_W'(e_c);
			sq_sd[0]            <= '0;
			hq_sd[0]            <= '0;

			for (int k = 0; k < NSTG; k++) begin
				pay_sd[k+1]  <= pay_sd[k];
				srem_sd[k+1] <= srem_nx[k];
				hrem_sd[k+1] <= hrem_nx[k];
				sq_sd[k+1]   <= {sq_sd[k][NSTG-2:0], sbit[k]};
				hq_sd[k+1]   <= {hq_sd[k][NSTG-2:0], hbit[k]};
			end

			nr_q  <= pay_sd[NSTG].neg_red;
			ng_q  <= pay_sd[NSTG].neg_green;
			nb_q  <= pay_sd[NSTG].neg_blue;
			val_q <= pay_sd[NSTG].mx;
			sat_q <= pay_sd[NSTG].black ? '0 : sq_sd[NSTG][CB-1:0];
			hue_q <= pay_sd[NSTG].gray ? '0 : hwrap_c[HUE_W-1:0];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'({hue_q, sat_q, val_q, nb_q, ng_q, nr_q});

endmodule

FILE: tb/rgb_to_hsv_negative_top_tb.sv
// Self-checking testbench for the pixel negative and HSV converter.
module rgb_to_hsv_negative_top_tb
	import rgb2hsv_pkg::*;
();

	localparam int COMPONENT_BITS    = 8;
	localparam int HUE_FRACTION_BITS = 4;
	localparam int FULL_SCALE        = (1 << COMPONENT_BITS) - 1;
	localparam int HUE_STEP          = 1 << HUE_FRACTION_BITS;
	localparam int HUE_TURN          = 360 * HUE_STEP;
	localparam int LATENCY           = 14;
	localparam int CYCLE_LIMIT       = 400000;
	localparam int PHASE_PIXELS      = 166;

	typedef struct {
		logic [7:0]  neg_red;
		logic [7:0]  neg_green;
		logic [7:0]  neg_blue;
		logic [7:0]  value_level;
		logic [7:0]  saturation_level;
		logic [12:0] hue_angle;
	} hsv_result_t;

	class hsv_scoreboard;
		logic        swap_red_blue;
		hsv_result_t expected_q[$];
		int          errors;

		function new();
			swap_red_blue = SWAP_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			if ((addr >> 2) == REG_SWAP_RED_BLUE) begin
				swap_red_blue = data[0];
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function hsv_result_t convert_pixel(logic [23:0] pix);
			hsv_result_t res;
			hue_sector_t sector;
			int r, g, b, mx, mn, d, base, diff, num, h;
			r = swap_red_blue ? int'(pix[23:16]) : int'(pix[7:0]);
			g = int'(pix[15:8]);
			b = swap_red_blue ? int'(pix[7:0]) : int'(pix[23:16]);
			mx = (r > g) ? r : g;
			mx = (mx > b) ? mx : b;
			mn = (r < g) ? r : g;
			mn = (mn < b) ? mn : b;
			d = mx - mn;
			if (mx == r) begin
				sector = SEC_RED;
			end else if (mx == g) begin
				sector = SEC_GREEN;
			end else begin
				sector = SEC_BLUE;
			end
			case (sector)
				SEC_RED: begin
					base = HUE_TURN;
					diff = g - b;
				end
				SEC_GREEN: begin
					base = 120 * HUE_STEP;
					diff = b - r;
				end
				default: begin
					base = 240 * HUE_STEP;
					diff = r - g;
				end
			endcase
			if (d == 0) begin
				h = 0;
			end else begin
				// The offset keeps the numerator non-negative, so the division floors.
				num = base * d + 60 * HUE_STEP * diff;
				h = num / d;
				if (h >= HUE_TURN) begin
					h = h - HUE_TURN;
				end
			end
			res.neg_red = 8'(FULL_SCALE - r);
			res.neg_green = 8'(FULL_SCALE - g);
			res.neg_blue = 8'(FULL_SCALE - b);
			res.value_level = 8'(mx);
			res.saturation_level = (mx == 0) ? 8'd0 : 8'((FULL_SCALE * d) / mx);
			res.hue_angle = 13'(h);
			return res;
		endfunction

		function void note_pixel(logic [23:0] pix);
			expected_q.push_back(convert_pixel(pix));
		endfunction

		function void check_result(logic [55:0] data);
			hsv_result_t exp;
			if (expected_q.size() == 0) begin
				$error("result %h arrived with no pixel outstanding", data);
				errors++;
			end else begin
				exp = expected_q.pop_front();
				if (data[7:0] !== exp.neg_red) begin
					$error("neg_red: expected %0d, actual %0d", exp.neg_red, data[7:0]);
					errors++;
				end
				if (data[15:8] !== exp.neg_green) begin
					$error("neg_green: expected %0d, actual %0d", exp.neg_green, data[15:8]);
					errors++;
				end
				if (data[23:16] !== exp.neg_blue) begin
					$error("neg_blue: expected %0d, actual %0d", exp.neg_blue, data[23:16]);
					errors++;
				end
				if (data[31:24] !== exp.value_level) begin
					$error("value_level: expected %0d, actual %0d",
						exp.value_level, data[31:24]);
					errors++;
				end
				if (data[39:32] !== exp.saturation_level) begin
					$error("saturation_level: expected %0d, actual %0d",
						exp.saturation_level, data[39:32]);
					errors++;
				end
				if (data[52:40] !== exp.hue_angle) begin
					$error("hue_angle: expected %0d, actual %0d", exp.hue_angle, data[52:40]);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// first_component, green_component, third_component
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// neg_red, neg_green, neg_blue, value_level, saturation_level, hue_angle
	logic [55:0] m_tdata;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	hsv_scoreboard sb = new();

	rgb_to_hsv_negative_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (psel && penable && pwrite && pready) begin
			sb.write_reg(paddr, pwdata);
		end
		if (s_tvalid && s_tready) begin
			sb.note_pixel(s_tdata);
		end
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_pixel(input logic [23:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// Places red and blue according to the current swap setting.
	task automatic send_rgb(input int r, input int g, input int b);
		if (sb.swap_red_blue) begin
			send_pixel({8'(r), 8'(g), 8'(b)});
		end else begin
			send_pixel({8'(b), 8'(g), 8'(r)});
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 3));
			3: return 8'($urandom_range(252, 254));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [23:0] make_pixel();
		logic [7:0] a, c;
		a = pick_level();
		c = pick_level();
		case ($urandom_range(9))
			0: return {a, a, a};
			1: begin
				case ($urandom_range(2))
					0: return {a, a, c};
					1: return {a, c, a};
					default: return {c, a, a};
				endcase
			end
			default: return {pick_level(), a, c};
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: input arrives as BGR.
		send_rgb(0, 0, 0);
		send_rgb(255, 255, 255);
		send_rgb(128, 128, 128);
		send_rgb(255, 0, 0);
		send_rgb(0, 255, 0);
		send_rgb(0, 0, 255);
		send_rgb(255, 255, 0);
		send_rgb(0, 255, 255);
		send_rgb(255, 0, 255);
		send_rgb(255, 0, 1);
		send_rgb(1, 0, 0);
		send_rgb(1, 1, 0);
		send_rgb(0, 1, 1);
		send_rgb(255, 254, 0);
		send_rgb(200, 100, 150);
		send_rgb(254, 255, 1);
		wait_for_results();
		write_reg(3'd0, 32'd0);
		send_pixel(24'h0000ff);
		send_pixel(24'hff0000);
		send_pixel(24'h1e140a);
		send_pixel(24'h0a141e);
		send_pixel(24'h55aaff);

		for (int phase = 0; phase < 8; phase++) begin
			wait_for_results();
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					send_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			case (phase)
				0: write_reg(3'd0, 32'd1);
				1: write_reg(3'd4, 32'd0);
				2: write_reg(3'd0, 32'hffff_fffe);
				3: write_reg(3'd0, 32'h0000_0003);
				4: write_reg(3'd0, 32'd0);
				5: write_reg(3'd4, 32'hffff_ffff);
				6: write_reg(3'd0, 32'h8000_0001);
				default: write_reg(3'd0, 32'h8000_0000);
			endcase
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				if (phase == 3 && i == PHASE_PIXELS / 2) begin
					wait_for_results();
				end
				send_pixel(make_pixel());
			end
		end

		wait_for_results();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/rgb2hsv_pkg.sv
src/rgb_to_hsv_negative_top.sv
tb/rgb_to_hsv_negative_top_tb.sv
